@@ rtl/sol_pkg.sv @@
// Shared constants, types and helpers for the keystream decrypt unit.
`timescale 1ns / 1ps
package sol_pkg;

  localparam int CARD_W   = 6;
  localparam int DECK_N   = 54;
  localparam int LTR_W    = 5;
  localparam int IDX_W    = $clog2(DECK_N);

  localparam logic [CARD_W-1:0] JOKER_A  = 6'd53;
  localparam logic [CARD_W-1:0] JOKER_B  = 6'd54;
  localparam logic [CARD_W-1:0] TOP_CARD = 6'd52;
  localparam logic [IDX_W-1:0]  LAST_POS = 6'd53;
  localparam logic [IDX_W-1:0]  PASS_END = 6'd54;
  localparam logic [5:0]        ROUND_MAX = 6'd63;
  localparam logic [LTR_W-1:0]  ALPHA    = 5'd26;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_A,
    ST_MOVE_A,
    ST_SCAN_B,
    ST_MOVE_B,
    ST_SCAN_J,
    ST_TCUT,
    ST_BOT,
    ST_CCUT,
    ST_TOP,
    ST_PICK,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PM_IDENT,
    PM_RELOC,
    PM_TCUT,
    PM_CCUT
  } perm_t;

  typedef struct packed {
    perm_t            mode;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
  } src_ctl_t;

  function automatic logic [IDX_W-1:0] count_of(input logic [CARD_W-1:0] v);
    count_of = (v >= JOKER_A) ? LAST_POS : v;
  endfunction

endpackage

@@ rtl/sol_ram.sv @@
// Single-write, registered-read deck memory bank.
`timescale 1ns / 1ps
module sol_ram #(
  parameter int DEPTH = sol_pkg::DECK_N,
  parameter int WIDTH = sol_pkg::CARD_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sol_src.sv @@
// Source index unit: maps a target deck slot to the slot it is copied from.
`timescale 1ns / 1ps
module sol_src (
  input  sol_pkg::src_ctl_t             ctl,
  input  logic [sol_pkg::IDX_W-1:0]     k,
  output logic [sol_pkg::IDX_W-1:0]     src
);
  import sol_pkg::*;

  logic [7:0] k8, a8, b8, len_c, seg2;

  assign k8    = {2'b00, k};
  assign a8    = {2'b00, ctl.a};
  assign b8    = {2'b00, ctl.b};
  assign len_c = 8'd53 - b8;
  assign seg2  = 8'd54 - a8;

  always_comb begin
    src = k;
    case (ctl.mode)
      PM_RELOC: begin
        if (a8 < b8) begin
          if (k8 < a8 || k8 > b8) src = k;
          else if (k8 < b8)       src = IDX_W'(k8 + 8'd1);
          else                    src = ctl.a;
        end else if (a8 > b8) begin
          if (k8 < b8 || k8 > a8) src = k;
          else if (k8 == b8)      src = ctl.a;
          else                    src = IDX_W'(k8 - 8'd1);
        end
      end
      PM_TCUT: begin
        if (k8 < len_c)     src = IDX_W'(b8 + 8'd1 + k8);
        else if (k8 < seg2) src = IDX_W'(k8 + a8 + b8 - 8'd53);
        else                src = IDX_W'(k8 + a8 - 8'd54);
      end
      PM_CCUT: begin
        if (k == LAST_POS)           src = LAST_POS;
        else if (k8 < 8'd53 - a8)    src = IDX_W'(a8 + k8);
        else                         src = IDX_W'(k8 + a8 - 8'd53);
      end
      default: src = k;
    endcase
  end

endmodule

@@ rtl/solitaire_keystream_decrypt_unit.sv @@
// Top level: deck sequencer, ping-pong deck banks and result register.
// Load word: written to the current bank as it is taken (positions 0..53). Decrypt word: one Solitaire round
// after another (four to seven deck passes through the shared index unit plus three
// reads per round), up to 64 rounds; the single read port of each bank sets the pace.
// After reset a clearing pass writes cards 1..54; no word is taken meanwhile.
// The result register holds one finished word while the next one is taken.
`timescale 1ns / 1ps
module solitaire_keystream_decrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[0], position[6:1], card[12:7], cipher_letter[17:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // plain_letter[4:0], key_card[10:5]
);
  import sol_pkg::*;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              cur_r, cur_nxt;
  logic [IDX_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt, n_r, n_nxt;
  logic              v1_r, v1_nxt, v2_r, v2_nxt;
  logic [5:0]        round_r, round_nxt;
  logic [LTR_W-1:0]  ciph_r, ciph_nxt;
  logic [CARD_W-1:0] key_r, key_nxt;
  logic [LTR_W-1:0]  out_plain_r, out_plain_nxt;
  logic [CARD_W-1:0] out_key_r, out_key_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_acc, in_op;
  logic [IDX_W-1:0]  in_pos;
  logic [CARD_W-1:0] in_card;
  logic [LTR_W-1:0]  in_ciph;

  logic [CARD_W-1:0] rd0, rd1, rd_cur;
  logic [IDX_W-1:0]  idx, raddr, src, to_a, to_b;
  src_ctl_t          sctl;
  logic              wr_en, wr_bank;
  logic [IDX_W-1:0]  wr_addr;
  logic [CARD_W-1:0] wr_data;
  logic              hit_a, hit_b, hit_j, found1, found2, pass_done;
  logic [LTR_W-1:0]  c1, k1, plain;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tdata[0];
  assign in_pos    = in_tdata[6:1];
  assign in_card   = in_tdata[12:7];
  assign in_ciph   = in_tdata[17:13];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_key_r, out_plain_r};

  assign rd_cur    = cur_r ? rd1 : rd0;
  assign idx       = cnt_r - 6'd1;
  assign pass_done = (cnt_r == PASS_END);
  assign hit_a     = (cnt_r != '0) && (rd_cur == JOKER_A);
  assign hit_b     = (cnt_r != '0) && (rd_cur == JOKER_B);
  assign hit_j     = (cnt_r != '0) && (rd_cur > TOP_CARD);
  assign found1    = v1_r || ((state_r == ST_SCAN_A) ? hit_a : hit_b);
  assign found2    = v2_r || (hit_j && v1_r);

  assign to_a = (p1_r == LAST_POS) ? 6'd1 : p1_r + 6'd1;
  assign to_b = (p1_r == LAST_POS) ? 6'd2 :
                (p1_r == LAST_POS - 6'd1) ? 6'd1 : p1_r + 6'd2;

  always_comb begin
    sctl = '{mode: PM_IDENT, a: p1_r, b: p2_r};
    case (state_r)
      ST_MOVE_A: sctl = '{mode: PM_RELOC, a: p1_r, b: to_a};
      ST_MOVE_B: sctl = '{mode: PM_RELOC, a: p1_r, b: to_b};
      ST_TCUT:   sctl = '{mode: PM_TCUT, a: p1_r, b: p2_r};
      ST_CCUT:   sctl = '{mode: PM_CCUT, a: n_r, b: p2_r};
      default:   sctl = '{mode: PM_IDENT, a: p1_r, b: p2_r};
    endcase
  end

  sol_src u_src (
    .ctl (sctl),
    .k   (cnt_r),
    .src (src)
  );

  always_comb begin
    case (state_r)
      ST_SCAN_A, ST_MOVE_A, ST_SCAN_B, ST_MOVE_B, ST_SCAN_J, ST_TCUT, ST_CCUT:
        raddr = (cnt_r < PASS_END) ? src : '0;
      ST_BOT:  raddr = LAST_POS;
      ST_PICK: raddr = n_r;
      default: raddr = '0;
    endcase
  end

  sol_ram #(.DEPTH(DECK_N), .WIDTH(CARD_W)) u_bank0 (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd0)
  );

  sol_ram #(.DEPTH(DECK_N), .WIDTH(CARD_W)) u_bank1 (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd1)
  );

  assign c1 = (ciph_r >= ALPHA) ? ciph_r - ALPHA : ciph_r;
  assign k1 = (key_r >= 6'd52) ? LTR_W'(key_r - 6'd52) :
              (key_r >= 6'd26) ? LTR_W'(key_r - 6'd26) : LTR_W'(key_r);
  assign plain = (c1 >= k1) ? c1 - k1 : c1 + ALPHA - k1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (cnt_r == LAST_POS) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc && in_op == OP_DECRYPT) state_nxt = ST_SCAN_A;
      ST_SCAN_A: if (pass_done) state_nxt = found1 ? ST_MOVE_A : ST_SCAN_B;
      ST_MOVE_A: if (pass_done) state_nxt = ST_SCAN_B;
      ST_SCAN_B: if (pass_done) state_nxt = found1 ? ST_MOVE_B : ST_SCAN_J;
      ST_MOVE_B: if (pass_done) state_nxt = ST_SCAN_J;
      ST_SCAN_J: if (pass_done) state_nxt = found2 ? ST_TCUT : ST_BOT;
      ST_TCUT:   if (pass_done) state_nxt = ST_BOT;
      ST_BOT:    if (cnt_r == 6'd1) state_nxt = ST_CCUT;
      ST_CCUT:   if (pass_done) state_nxt = ST_TOP;
      ST_TOP:    if (cnt_r == 6'd1) state_nxt = ST_PICK;
      ST_PICK: begin
        if (cnt_r == 6'd1) begin
          if (rd_cur <= TOP_CARD || round_r == ROUND_MAX) state_nxt = ST_OUT;
          else state_nxt = ST_SCAN_A;
        end
      end
      ST_OUT:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = (state_nxt != state_r) ? '0 : cnt_r + 6'd1;
    cur_nxt       = cur_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    n_nxt         = n_r;
    round_nxt     = round_r;
    ciph_nxt      = ciph_r;
    key_nxt       = key_r;
    out_plain_nxt = out_plain_r;
    out_key_nxt   = out_key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_bank       = cur_r;
    wr_addr       = idx;
    wr_data       = rd_cur;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = cnt_r + 6'd1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_LOAD) begin
            wr_en   = (in_pos <= LAST_POS);
            wr_addr = in_pos;
            wr_data = in_card;
          end else begin
            ciph_nxt  = in_ciph;
            round_nxt = '0;
          end
        end
      end
      ST_SCAN_A, ST_SCAN_B: begin
        if (!v1_r && ((state_r == ST_SCAN_A) ? hit_a : hit_b)) begin
          p1_nxt = idx;
          v1_nxt = 1'b1;
        end
      end
      ST_SCAN_J: begin
        if (hit_j) begin
          if (!v1_r) begin
            p1_nxt = idx;
            v1_nxt = 1'b1;
          end else if (!v2_r) begin
            p2_nxt = idx;
            v2_nxt = 1'b1;
          end
        end
      end
      ST_MOVE_A, ST_MOVE_B, ST_TCUT, ST_CCUT: begin
        wr_bank = !cur_r;
        wr_en   = (cnt_r != '0);
        if (pass_done) cur_nxt = !cur_r;
      end
      ST_BOT, ST_TOP: begin
        if (cnt_r == 6'd1) n_nxt = count_of(rd_cur);
      end
      ST_PICK: begin
        if (cnt_r == 6'd1) begin
          if (rd_cur <= TOP_CARD) key_nxt = rd_cur;
          else if (round_r == ROUND_MAX) key_nxt = '0;
          else round_nxt = round_r + 6'd1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_plain_nxt = plain;
          out_key_nxt   = key_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_nxt != state_r &&
        (state_nxt == ST_SCAN_A || state_nxt == ST_SCAN_B || state_nxt == ST_SCAN_J)) begin
      v1_nxt = 1'b0;
      v2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cur_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    n_r         <= n_nxt;
    ciph_r      <= ciph_nxt;
    key_r       <= key_nxt;
    out_plain_r <= out_plain_nxt;
    out_key_r   <= out_key_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PASS_END || state_r == ST_IDLE || state_r == ST_OUT)
    else $error("pass counter beyond deck pass");

  a_key_no_joker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_key_r <= TOP_CARD)
    else $error("joker presented as key card");

  a_plain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_plain_r < ALPHA)
    else $error("plain letter out of range");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_LOAD) |=> state_r == ST_IDLE)
    else $error("load word left idle");

endmodule
